### design/loop_coverage_sampling_counters_unit_macros.svh
// ----------------------------------------------------------------------------
// loop coverage sampling counters: assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LOOP_COVERAGE_SAMPLING_COUNTERS_UNIT_MACROS_SVH
`define LOOP_COVERAGE_SAMPLING_COUNTERS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define LCSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcsc assertion failed");
// antecedent implies consequent in the next cycle
`define LCSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcsc assertion failed");
`else
`define LCSC_ASSERT_IMP(label, clk, rst, ante, cons)
`define LCSC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### design/lcsc_pkg.sv
// ----------------------------------------------------------------------------
// lcsc_pkg
// item types and event codes of the loop coverage sampling counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcsc_pkg;

   localparam int MODE_W     = 3;
   localparam int ID_W       = 8;
   localparam int ADDR_W     = 32;
   localparam int OUT_CNT_W  = 48;

   // event codes; anything else reads the row
   localparam logic [MODE_W-1:0] MODE_START = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ITER  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_END   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TICK  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   loop_id;
      logic [ADDR_W-1:0] loop_addr;
   } req_type;

   typedef struct packed {
      logic [OUT_CNT_W-1:0] iteration_count;
      logic [OUT_CNT_W-1:0] invocation_count;
      logic                 suspicious_flag;
      logic [OUT_CNT_W-1:0] sample_count;
      logic [ADDR_W-1:0]    start_address;
      logic                 is_live;
      logic [OUT_CNT_W-1:0] total_ticks;
   } rsp_type;

endpackage

### design/lcsc_row_mem.sv
// ----------------------------------------------------------------------------
// lcsc_row_mem
// one-port-write, one-port-read row memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcsc_row_mem #(
   parameter int DEPTH  = 256,
   parameter int DATA_W = 178,
   parameter int IDX_W  = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lcsc_row_update.sv
// ----------------------------------------------------------------------------
// lcsc_row_update
// applies one event to a row and forms the result item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcsc_row_update
   import lcsc_pkg::*;
#(
   parameter int COUNT_BITS = 48,
   parameter int ROW_W      = 3 * COUNT_BITS + 34
) (
   input  req_type               req,
   input  logic                  in_range,
   input  logic [ROW_W-1:0]      row_in,
   input  logic [COUNT_BITS-1:0] tick_cur,
   output logic [ROW_W-1:0]      row_out,
   output logic [COUNT_BITS-1:0] tick_next,
   output rsp_type               rsp
);

   localparam int C = COUNT_BITS;

   logic [C-1:0]      iter, invoc, offs;
   logic              susp, live;
   logic [ADDR_W-1:0] addr;
   logic [C-1:0]      iter_new, invoc_new, offs_new, sample;
   logic              susp_new, live_new;
   logic [ADDR_W-1:0] addr_new;
   logic [63:0]       iter_wide, invoc_wide, sample_wide, tick_wide;

   // row layout, low to high: iter, invoc, susp, offset, addr, live
   assign iter  = row_in[C-1:0];
   assign invoc = row_in[2*C-1:C];
   assign susp  = row_in[2*C];
   assign offs  = row_in[3*C:2*C+1];
   assign addr  = row_in[3*C+ADDR_W:3*C+1];
   assign live  = row_in[3*C+ADDR_W+1];

   assign tick_next = (req.mode == MODE_TICK) ? tick_cur + C'(1) : tick_cur;

   // offset holds the sample count while idle, and count minus the
   // tick total while live
   always_comb begin
      iter_new  = iter;
      invoc_new = invoc;
      susp_new  = susp;
      offs_new  = offs;
      addr_new  = addr;
      live_new  = live;
      case (req.mode)
         MODE_START: begin
            if (!live) begin
               offs_new = offs - tick_cur;
            end
            live_new = 1'b1;
            addr_new = req.loop_addr;
         end
         MODE_ITER: begin
            iter_new = iter + C'(1);
         end
         MODE_END: begin
            if (live) begin
               live_new  = 1'b0;
               offs_new  = offs + tick_cur;
               invoc_new = invoc + C'(1);
            end else begin
               susp_new = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // count after this item, from the row as it was read
   assign sample = live ? offs + tick_next : offs;

   assign row_out = {live_new, addr_new, offs_new, susp_new, invoc_new, iter_new};

   assign iter_wide   = 64'(iter_new);
   assign invoc_wide  = 64'(invoc_new);
   assign sample_wide = 64'(sample);
   assign tick_wide   = 64'(tick_next);

   always_comb begin
      rsp.total_ticks = tick_wide[OUT_CNT_W-1:0];
      if (in_range) begin
         rsp.iteration_count  = iter_wide[OUT_CNT_W-1:0];
         rsp.invocation_count = invoc_wide[OUT_CNT_W-1:0];
         rsp.suspicious_flag  = susp_new;
         rsp.sample_count     = sample_wide[OUT_CNT_W-1:0];
         rsp.start_address    = addr_new;
         rsp.is_live          = live_new;
      end else begin
         rsp.iteration_count  = '0;
         rsp.invocation_count = '0;
         rsp.suspicious_flag  = 1'b0;
         rsp.sample_count     = '0;
         rsp.start_address    = '0;
         rsp.is_live          = 1'b0;
      end
   end

endmodule

### design/loop_coverage_sampling_counters_unit.sv
// ----------------------------------------------------------------------------
// loop_coverage_sampling_counters_unit: per-loop profiling counters
// row read at the accepting edge, then the update step loads the result register
// one item at a time: a new item waits until the last one's read-modify-write is done
// a stalled result holds the update step, and with it the next item
// reset: synchronous; a clearing pass then zeroes all rows in turn, no item taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "loop_coverage_sampling_counters_unit_macros.svh"

module loop_coverage_sampling_counters_unit
   import lcsc_pkg::*;
#(
   parameter int NUM_LOOPS  = 256,
   parameter int COUNT_BITS = 48
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(NUM_LOOPS);
   // live, addr, sample offset, suspicious, invocations, iterations
   localparam int ROW_W = 3 * COUNT_BITS + ADDR_W + 2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       clr_cnt_ff, clr_cnt_in;
   req_type                req_ff, req_in;
   logic                   range_ff, range_in;
   logic [COUNT_BITS-1:0]  tick_ff, tick_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   req_accept;
   logic                   exec_go;
   logic [31:0]            id_wide, id_ff_wide;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_widx;
   logic [ROW_W-1:0]       mem_wdata;
   logic [ROW_W-1:0]       mem_rdata;
   logic [ROW_W-1:0]       row_new;
   logic [COUNT_BITS-1:0]  tick_next;
   rsp_type                rsp_calc;

   // only idle takes an item; the row is read at the accept edge
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign id_wide    = 32'(req_data.loop_id);
   assign id_ff_wide = 32'(req_ff.loop_id);

   // the update runs once the output register is free or being drained
   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // row memory; a loop id past the table writes nothing
   assign mem_we    = (state_ff == ST_CLEAR) || (exec_go && range_ff);
   assign mem_widx  = (state_ff == ST_CLEAR) ? clr_cnt_ff : id_ff_wide[IDX_W-1:0];
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : row_new;

   lcsc_row_mem #(
      .DEPTH  (NUM_LOOPS),
      .DATA_W (ROW_W),
      .IDX_W  (IDX_W)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_idx  (mem_widx),
      .wr_data (mem_wdata),
      .rd_en   (req_accept),
      .rd_idx  (id_wide[IDX_W-1:0]),
      .rd_data (mem_rdata)
   );

   // sample counts never walk the table: a live row keeps its count
   // relative to the global tick total, so a tick is one counter bump
   lcsc_row_update #(
      .COUNT_BITS (COUNT_BITS),
      .ROW_W      (ROW_W)
   ) u_row_update (
      .req       (req_ff),
      .in_range  (range_ff),
      .row_in    (mem_rdata),
      .tick_cur  (tick_ff),
      .row_out   (row_new),
      .tick_next (tick_next),
      .rsp       (rsp_calc)
   );

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      req_in       = req_ff;
      range_in     = range_ff;
      tick_in      = tick_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // result leaves the output register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == IDX_W'(NUM_LOOPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               req_in   = req_data;
               range_in = (id_wide < 32'(NUM_LOOPS));
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               tick_in      = tick_next;
               rsp_in       = rsp_calc;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      range_ff <= range_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted item always moves to the update step
   `LCSC_ASSERT_NXT(a_accept_exec, clock, reset, req_accept, state_ff == ST_EXEC)
   // writes come only from the clearing pass or an update
   `LCSC_ASSERT_IMP(a_write_src, clock, reset, mem_we, (state_ff == ST_CLEAR) || exec_go)
   // a new result only follows an update step
   `LCSC_ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_valid_ff), $past(exec_go))
   // no two items back to back: one read-modify-write at a time
   `LCSC_ASSERT_NXT(a_one_at_a_time, clock, reset, req_accept, !req_accept)
   // the tick total moves only on a tick update
   `LCSC_ASSERT_IMP(a_tick_move, clock, reset, !$stable(tick_ff),
      $past(exec_go) && ($past(req_ff.mode) == MODE_TICK))

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: loop coverage sampling counters testbench
// drives loop events through the request channel, keeps a shadow copy of
// every profiling row and checks each returned row field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import lcsc_pkg::*;

   // block configuration, matches the instance below
   localparam int NUM_LOOPS  = 256;
   localparam int COUNT_BITS = 48;

   // run control
   localparam int RESET_CYCLES = 9;
   localparam int TAIL_CYCLES  = 20;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int IDLE_PCT     = 6;
   localparam int POOL_SIZE    = 6;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the profiling tables
   bit                    live_tbl   [NUM_LOOPS];
   logic [COUNT_BITS-1:0] iter_tbl   [NUM_LOOPS];
   logic [COUNT_BITS-1:0] invoc_tbl  [NUM_LOOPS];
   bit                    susp_tbl   [NUM_LOOPS];
   logic [COUNT_BITS-1:0] sample_tbl [NUM_LOOPS];
   logic [ADDR_W-1:0]     addr_tbl   [NUM_LOOPS];
   logic [COUNT_BITS-1:0] tick_total;

   // rows still owed by the block, oldest first
   rsp_type rows_expected[$];

   int     error_count = 0;
   longint cycle_count = 0;
   bit     idle_on = 1'b1;   // random gaps and stalls enabled
   int     stall_left = 0;
   logic [ID_W-1:0] id_pool[POOL_SIZE];

   loop_coverage_sampling_counters_unit #(
      .NUM_LOOPS  (NUM_LOOPS),
      .COUNT_BITS (COUNT_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // watchdog: a hung handshake or a lost row ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d rows outstanding", $time,
                  cycle_count, rows_expected.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // row predictor: applies one event to the shadow tables and returns the
   // row of the addressed loop as it stands afterwards
   // ---------------------------------------------------------------------
   function automatic rsp_type predict_row(input req_type item);
      rsp_type row;
      int      idx;
      bit      in_range;
      idx      = int'(item.loop_id);
      in_range = idx < NUM_LOOPS;
      row      = '0;
      if (item.mode == MODE_TICK) begin
         // a tick counts globally and bumps every live row, whatever the id
         tick_total = tick_total + COUNT_BITS'(1);
         for (int k = 0; k < NUM_LOOPS; k++)
            if (live_tbl[k]) sample_tbl[k] = sample_tbl[k] + COUNT_BITS'(1);
      end else if (in_range) begin
         case (item.mode)
            MODE_START: begin
               // a repeated start keeps the loop live and takes the new address
               live_tbl[idx] = 1'b1;
               addr_tbl[idx] = item.loop_addr;
            end
            MODE_ITER: begin
               iter_tbl[idx] = iter_tbl[idx] + COUNT_BITS'(1);
            end
            MODE_END: begin
               if (live_tbl[idx]) begin
                  live_tbl[idx]  = 1'b0;
                  invoc_tbl[idx] = invoc_tbl[idx] + COUNT_BITS'(1);
               end else begin
                  // end without a start: sticky flag
                  susp_tbl[idx] = 1'b1;
               end
            end
            default: ;   // read row and unused codes change nothing
         endcase
      end
      if (in_range) begin
         row.iteration_count  = iter_tbl[idx];
         row.invocation_count = invoc_tbl[idx];
         row.suspicious_flag  = susp_tbl[idx];
         row.sample_count     = sample_tbl[idx];
         row.start_address    = addr_tbl[idx];
         row.is_live          = live_tbl[idx];
      end
      row.total_ticks = tick_total;
      return row;
   endfunction

   function automatic req_type make_item(input logic [MODE_W-1:0] mode,
                                         input logic [ID_W-1:0]   id,
                                         input logic [ADDR_W-1:0] addr);
      req_type item;
      item.mode      = mode;
      item.loop_id   = id;
      item.loop_addr = addr;
      return item;
   endfunction

   // ---------------------------------------------------------------------
   // sender: optional random gap, then hold the item until it is taken;
   // the row is predicted at the accepting edge
   // ---------------------------------------------------------------------
   task automatic send_item(input req_type item);
      int gap;
      if (idle_on && $urandom_range(99) < IDLE_PCT) begin
         gap = $urandom_range(4, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rows_expected.insert(rows_expected.size(), predict_row(item));
   endtask

   // sender holds off until the block has returned every row
   task automatic drain_rows();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rows_expected.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                  exp_val, act_val);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // receiver: checks each accepted row against the oldest prediction and
   // stalls at random in short bursts
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rows_expected.size() == 0) begin
               $display("%0t: row returned with none expected, expected none, actual %h",
                        $time, rsp_data);
               error_count++;
            end else begin
               want = rows_expected.pop_front();
               check_field("iteration_count", 64'(want.iteration_count),
                           64'(rsp_data.iteration_count));
               check_field("invocation_count", 64'(want.invocation_count),
                           64'(rsp_data.invocation_count));
               check_field("suspicious_flag", 64'(want.suspicious_flag),
                           64'(rsp_data.suspicious_flag));
               check_field("sample_count", 64'(want.sample_count),
                           64'(rsp_data.sample_count));
               check_field("start_address", 64'(want.start_address),
                           64'(rsp_data.start_address));
               check_field("is_live", 64'(want.is_live), 64'(rsp_data.is_live));
               check_field("total_ticks", 64'(want.total_ticks),
                           64'(rsp_data.total_ticks));
            end
         end
         // random stall bursts, held while stall_left counts down
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            stall_left <= $urandom_range(1, 0);
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------------

   // rows at both ends of the table read back cleared
   task automatic test_cleared_rows();
      send_item(make_item(MODE_READ, 8'h00, 32'h0000_0000));
      send_item(make_item(MODE_READ, 8'hFF, 32'hFFFF_FFFF));
   endtask

   // start, repeated start, iterations, end, end without start
   task automatic test_loop_lifecycle();
      send_item(make_item(MODE_START, 8'hAA, 32'hFFFF_FFFF));
      send_item(make_item(MODE_START, 8'hAA, 32'h0000_0000));
      send_item(make_item(MODE_ITER,  8'hAA, 32'hFFFF_FFFF));
      send_item(make_item(MODE_ITER,  8'hAA, 32'h0000_0000));
      // tick reports the row named by its id, here a loop that is not live
      send_item(make_item(MODE_TICK,  8'h00, 32'h5A5A_5A5A));
      send_item(make_item(MODE_END,   8'hAA, 32'h0000_0000));
      send_item(make_item(MODE_END,   8'hAA, 32'h0000_0000));
      send_item(make_item(MODE_READ,  8'hAA, 32'h0000_0000));
      // flag stays set across a new start and a clean end
      send_item(make_item(MODE_START, 8'hAA, 32'h1234_5678));
      send_item(make_item(MODE_END,   8'hAA, 32'h0000_0000));
   endtask

   // unused codes behave as a read
   task automatic test_unknown_modes();
      send_item(make_item(3'd5, 8'hAA, $urandom));
      send_item(make_item(3'd6, 8'hAA, $urandom));
      send_item(make_item(3'd7, 8'h55, $urandom));
   endtask

   // ticks bump only the live rows
   task automatic test_tick_walk();
      send_item(make_item(MODE_START, 8'h00, 32'h0000_0001));
      send_item(make_item(MODE_START, 8'hFF, 32'h8000_0000));
      send_item(make_item(MODE_START, 8'h55, 32'hA5A5_A5A5));
      send_item(make_item(MODE_TICK,  8'h55, 32'h0000_0000));
      send_item(make_item(MODE_TICK,  8'h7F, 32'h0000_0000));
      send_item(make_item(MODE_END,   8'hFF, 32'h0000_0000));
      send_item(make_item(MODE_TICK,  8'hFF, 32'h0000_0000));
      send_item(make_item(MODE_ITER,  8'h00, 32'h0000_0000));
      send_item(make_item(MODE_READ,  8'h00, 32'h0000_0000));
      send_item(make_item(MODE_READ,  8'hFF, 32'h0000_0000));
   endtask

   // ---------------------------------------------------------------------
   // random traffic: a small pool of loops walked through start / iterate /
   // end sequences, with ticks and reads mixed in, plus some pure noise
   // ---------------------------------------------------------------------
   function automatic req_type random_item();
      int              pick;
      int              slot;
      int              sel;
      logic [ID_W-1:0] id;
      logic [MODE_W-1:0] mode;
      pick = $urandom_range(99);
      if (pick < 10)
         return make_item(MODE_W'($urandom_range(7)), ID_W'($urandom_range(NUM_LOOPS - 1)),
                          $urandom);
      slot = $urandom_range(POOL_SIZE - 1);
      // occasionally retire a pool entry and bring in a fresh loop
      if (pick < 13) id_pool[slot] = ID_W'($urandom_range(NUM_LOOPS - 1));
      id  = id_pool[slot];
      sel = $urandom_range(99);
      if (!live_tbl[id]) begin
         if (sel < 70)      mode = MODE_START;
         else if (sel < 82) mode = MODE_END;    // broken sequence
         else if (sel < 92) mode = MODE_ITER;
         else               mode = MODE_READ;
      end else begin
         if (sel < 60)      mode = MODE_ITER;
         else if (sel < 80) mode = MODE_END;
         else if (sel < 85) mode = MODE_START;
         else if (sel < 91) mode = MODE_TICK;
         else               mode = MODE_READ;
      end
      return make_item(mode, id, $urandom);
   endfunction

   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++) send_item(random_item());
   endtask

   // long back to back stretch with no gaps or stalls on either side
   task automatic test_back_to_back(input int count);
      drain_rows();
      idle_on = 1'b0;
      test_random_traffic(count);
      drain_rows();
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      for (int k = 0; k < NUM_LOOPS; k++) begin
         live_tbl[k]   = 1'b0;
         iter_tbl[k]   = '0;
         invoc_tbl[k]  = '0;
         susp_tbl[k]   = 1'b0;
         sample_tbl[k] = '0;
         addr_tbl[k]   = '0;
      end
      tick_total = '0;
      for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = ID_W'($urandom_range(NUM_LOOPS - 1));

      // single reset at start; the block then clears its rows on its own
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cleared_rows();
      test_loop_lifecycle();
      test_unknown_modes();
      test_tick_walk();
      test_random_traffic(500);
      // sender waits out every pending row before going on
      drain_rows();
      test_random_traffic(200);
      test_back_to_back(300);
      test_random_traffic(300);

      // wind down: all rows back, then a short tail for stray outputs
      drain_rows();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && rows_expected.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
